// File: hw/rtl/c_style_byte_tokenizer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the byte tokenizer
// ---------------------------------------------------------------------------
`ifndef C_STYLE_BYTE_TOKENIZER_MACROS_SVH
`define C_STYLE_BYTE_TOKENIZER_MACROS_SVH

// condition holds at every clock edge out of reset
`define CTOK_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// pre at one edge implies post at the next
`define CTOK_CHECK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/ctok_pkg.sv
// ---------------------------------------------------------------------------
// ctok_pkg
// Shared types and constants of the byte tokenizer.
// ---------------------------------------------------------------------------
package ctok_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_DOT     = 6'd8;
    localparam logic [5:0] K_PLUS    = 6'd10;
    localparam logic [5:0] K_MINUS   = 6'd13;
    localparam logic [5:0] K_STAR    = 6'd16;
    localparam logic [5:0] K_SLASH   = 6'd18;
    localparam logic [5:0] K_MOD     = 6'd20;
    localparam logic [5:0] K_ASSIGN  = 6'd22;
    localparam logic [5:0] K_LESS    = 6'd24;
    localparam logic [5:0] K_SHL     = 6'd26;
    localparam logic [5:0] K_GREATER = 6'd28;
    localparam logic [5:0] K_SHR     = 6'd30;
    localparam logic [5:0] K_AND     = 6'd34;
    localparam logic [5:0] K_OR      = 6'd37;
    localparam logic [5:0] K_NOT     = 6'd40;
    localparam logic [5:0] K_XOR     = 6'd43;
    localparam logic [5:0] K_WORD    = 6'd45;
    localparam logic [5:0] K_INTEGER = 6'd46;
    localparam logic [5:0] K_FLOAT   = 6'd47;
    localparam logic [5:0] K_STRING  = 6'd48;
    localparam logic [5:0] K_ERROR   = 6'd49;

    localparam logic [3:0] E_NONE      = 4'd0;
    localparam logic [3:0] E_COMMENT   = 4'd1;
    localparam logic [3:0] E_STRING    = 4'd2;
    localparam logic [3:0] E_ZERO_DIG  = 4'd3;
    localparam logic [3:0] E_BIN       = 4'd4;
    localparam logic [3:0] E_OCT       = 4'd5;
    localparam logic [3:0] E_HEX       = 4'd6;
    localparam logic [3:0] E_DOT2      = 4'd7;
    localparam logic [3:0] E_EXP       = 4'd8;
    localparam logic [3:0] E_EXP2      = 4'd9;
    localparam logic [3:0] E_ISUF      = 4'd10;
    localparam logic [3:0] E_FSUF_POS  = 4'd11;
    localparam logic [3:0] E_FSUF2     = 4'd12;
    localparam logic [3:0] E_UNKNOWN   = 4'd13;

    localparam logic [4:0] M_IDLE  = 5'd0;
    localparam logic [4:0] M_OP    = 5'd1;
    localparam logic [4:0] M_OP2   = 5'd2;
    localparam logic [4:0] M_LCOM  = 5'd3;
    localparam logic [4:0] M_BCOM  = 5'd4;
    localparam logic [4:0] M_BSTAR = 5'd5;
    localparam logic [4:0] M_STR   = 5'd6;
    localparam logic [4:0] M_WORD  = 5'd7;
    localparam logic [4:0] M_ZERO  = 5'd8;
    localparam logic [4:0] M_BIN0  = 5'd9;
    localparam logic [4:0] M_BIN   = 5'd10;
    localparam logic [4:0] M_OCT0  = 5'd11;
    localparam logic [4:0] M_OCT   = 5'd12;
    localparam logic [4:0] M_HEX0  = 5'd13;
    localparam logic [4:0] M_HEX   = 5'd14;
    localparam logic [4:0] M_DEC   = 5'd15;
    localparam logic [4:0] M_ISUF  = 5'd16;
    localparam logic [4:0] M_FSUF  = 5'd17;

    localparam logic [2:0] P_INT        = 3'd0;
    localparam logic [2:0] P_FRAC       = 3'd1;
    localparam logic [2:0] P_AFTER_E    = 3'd2;
    localparam logic [2:0] P_AFTER_SIGN = 3'd3;
    localparam logic [2:0] P_EXP        = 3'd4;

    localparam logic [2:0] S_NONE  = 3'd0;
    localparam logic [2:0] S_FLOAT = 3'd7;

    // classified byte; every flag but eoi is low on end of input
    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
        logic       dig;
        logic       alp;
        logic       spc;
        logic       xdg;
        logic       bin;
        logic       oct;
        logic       wordc;
        logic       quote;
        logic       opst;
        logic       sk_ok;
        logic [5:0] sk;
        logic       nl;
        logic       star;
        logic       slash;
        logic       dot;
        logic       eq;
        logic       sign;
        logic       bslash;
        logic       zero;
        logic       lc_e;
        logic       lc_fl;
        logic       lc_u;
        logic       lc_l;
        logic       lc_b;
        logic       lc_o;
        logic       lc_x;
    } t_cls;

    typedef struct packed {
        logic [5:0] single;
        logic       eq_ok;
        logic [5:0] eq;
        logic       dbl_ok;
        logic [5:0] dbl;
    } t_opk;

    function automatic t_opk op_kinds(logic [7:0] p);
        t_opk k;
        k = '0;
        case (p)
            8'h2B: begin k.single = K_PLUS;  k.dbl_ok = 1'b1; k.dbl = K_PLUS + 6'd1;
                k.eq_ok = 1'b1; k.eq = K_PLUS + 6'd2; end
            8'h2D: begin k.single = K_MINUS; k.dbl_ok = 1'b1; k.dbl = K_MINUS + 6'd1;
                k.eq_ok = 1'b1; k.eq = K_MINUS + 6'd2; end
            8'h2A: begin k.single = K_STAR;  k.eq_ok = 1'b1; k.eq = K_STAR + 6'd1; end
            8'h2F: begin k.single = K_SLASH; k.eq_ok = 1'b1; k.eq = K_SLASH + 6'd1; end
            8'h25: begin k.single = K_MOD;   k.eq_ok = 1'b1; k.eq = K_MOD + 6'd1; end
            8'h3D: begin k.single = K_ASSIGN; k.eq_ok = 1'b1; k.eq = K_ASSIGN + 6'd1; end
            8'h3C: begin k.single = K_LESS;  k.eq_ok = 1'b1; k.eq = K_LESS + 6'd1;
                k.dbl_ok = 1'b1; k.dbl = K_SHL; end
            8'h3E: begin k.single = K_GREATER; k.eq_ok = 1'b1; k.eq = K_GREATER + 6'd1;
                k.dbl_ok = 1'b1; k.dbl = K_SHR; end
            8'h26: begin k.single = K_AND + 6'd2; k.dbl_ok = 1'b1; k.dbl = K_AND;
                k.eq_ok = 1'b1; k.eq = K_AND + 6'd1; end
            8'h7C: begin k.single = K_OR + 6'd2; k.dbl_ok = 1'b1; k.dbl = K_OR;
                k.eq_ok = 1'b1; k.eq = K_OR + 6'd1; end
            8'h21: begin k.single = K_NOT; k.eq_ok = 1'b1; k.eq = K_NOT + 6'd1; end
            8'h5E: begin k.single = K_XOR; k.eq_ok = 1'b1; k.eq = K_XOR + 6'd1; end
            default: k.single = K_DOT;
        endcase
        return k;
    endfunction

    // integer suffix steps: {ok, next} for u (sel 0) and l (sel 1)
    function automatic logic [3:0] isuf_next(logic [2:0] s, logic sel);
        logic [3:0] r;
        r = 4'b0000;
        case ({s, sel})
            4'b000_0: r = 4'b1_001;
            4'b000_1: r = 4'b1_100;
            4'b001_1: r = 4'b1_010;
            4'b010_1: r = 4'b1_011;
            4'b100_0: r = 4'b1_110;
            4'b100_1: r = 4'b1_101;
            4'b101_0: r = 4'b1_110;
            default:  r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/ctok_front.sv
// ---------------------------------------------------------------------------
// ctok_front
// Accepts source bytes, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module ctok_front
    import ctok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_input,
    output logic       o_cls_valid,
    output t_cls       o_cls,
    input  logic       i_cls_take
);

    t_cls       w_cls;
    logic [7:0] w_lb;
    logic       w_e;
    t_cls       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_push;

    always_comb begin
        w_lb  = (i_char_byte inside {[8'h41:8'h5A]}) ? i_char_byte + 8'd32 : i_char_byte;
        w_e   = !i_end_of_input;
        w_cls = '0;
        w_cls.b      = i_char_byte;
        w_cls.eoi    = i_end_of_input;
        w_cls.dig    = w_e && (i_char_byte inside {[8'h30:8'h39]});
        w_cls.alp    = w_e && (w_lb inside {[8'h61:8'h7A]});
        w_cls.spc    = w_e && (i_char_byte == 8'h20 || (i_char_byte inside {[8'd9:8'd13]}));
        w_cls.xdg    = w_cls.dig || (w_e && (w_lb inside {[8'h61:8'h66]}));
        w_cls.bin    = w_e && (i_char_byte == 8'h30 || i_char_byte == 8'h31);
        w_cls.oct    = w_e && (i_char_byte inside {[CH_ZERO:CH_SEVEN]});
        w_cls.wordc  = w_cls.alp || w_cls.dig || (w_e && i_char_byte == 8'h5F);
        w_cls.quote  = w_e && (i_char_byte == CH_DQUOTE || i_char_byte == CH_SQUOTE);
        w_cls.opst   = w_e && (i_char_byte inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25,
            8'h3D, 8'h3C, 8'h3E, 8'h26, 8'h7C, 8'h21, 8'h5E, CH_DOT});
        w_cls.sk_ok  = w_e;
        case (i_char_byte)
            8'h7B: w_cls.sk = 6'd1;
            8'h7D: w_cls.sk = 6'd2;
            8'h28: w_cls.sk = 6'd3;
            8'h29: w_cls.sk = 6'd4;
            8'h5B: w_cls.sk = 6'd5;
            8'h5D: w_cls.sk = 6'd6;
            8'h2C: w_cls.sk = 6'd7;
            8'h3F: w_cls.sk = 6'd9;
            8'h3A: w_cls.sk = 6'd32;
            8'h3B: w_cls.sk = 6'd33;
            8'h7E: w_cls.sk = 6'd42;
            default: begin
                w_cls.sk    = K_EOF;
                w_cls.sk_ok = 1'b0;
            end
        endcase
        w_cls.nl     = w_e && i_char_byte == CH_NL;
        w_cls.star   = w_e && i_char_byte == CH_STAR;
        w_cls.slash  = w_e && i_char_byte == CH_SLASH;
        w_cls.dot    = w_e && i_char_byte == CH_DOT;
        w_cls.eq     = w_e && i_char_byte == CH_EQ;
        w_cls.sign   = w_e && (i_char_byte == 8'h2B || i_char_byte == 8'h2D);
        w_cls.bslash = w_e && i_char_byte == CH_BSLASH;
        w_cls.zero   = w_e && i_char_byte == CH_ZERO;
        w_cls.lc_e   = w_e && w_lb == CH_E;
        w_cls.lc_fl  = w_e && (w_lb == 8'h66 || w_lb == 8'h6C);
        w_cls.lc_u   = w_e && w_lb == 8'h75;
        w_cls.lc_l   = w_e && w_lb == 8'h6C;
        w_cls.lc_b   = w_e && w_lb == 8'h62;
        w_cls.lc_o   = w_e && w_lb == 8'h6F;
        w_cls.lc_x   = w_e && w_lb == 8'h78;
    end

    assign o_in_ready  = r_cnt != 2'd2;
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cls_valid = r_cnt != 2'd0;
    assign o_cls       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (i_cls_take) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cls_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cls;
    end

endmodule

// File: hw/rtl/ctok_back.sv
// ---------------------------------------------------------------------------
// ctok_back
// Scanner state machine: one classified byte per cycle while the result queue
// has room; up to two results per byte into a four-entry result queue.
// ---------------------------------------------------------------------------
`include "c_style_byte_tokenizer_macros.svh"

module ctok_back
    import ctok_pkg::*;
#(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cls_valid,
    input  t_cls                    i_cls,
    output logic                    o_cls_take,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [5:0]              o_token_kind,
    output logic [3:0]              o_error_kind,
    output logic [LINE_WIDTH-1:0]   o_start_line,
    output logic [COLUMN_WIDTH-1:0] o_start_column,
    output logic [LINE_WIDTH-1:0]   o_end_line,
    output logic [COLUMN_WIDTH-1:0] o_end_column,
    output logic                    o_last
);

    localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
    localparam logic [COLUMN_WIDTH-1:0] COL_ONE  = COLUMN_WIDTH'(1);

    logic [4:0]              r_mode, n_mode;
    logic [2:0]              r_phase, n_phase;
    logic [2:0]              r_sfx, n_sfx;
    logic                    r_esc, n_esc;
    logic [7:0]              r_pch, n_pch;
    logic [LINE_WIDTH-1:0]   r_line, n_line, r_tsl, n_tsl;
    logic [COLUMN_WIDTH-1:0] r_col, n_col, r_tsc, n_tsc;

    logic [1:0]              w_n;
    logic [5:0]              w_rk [2];
    logic [3:0]              w_re [2];
    logic [LINE_WIDTH-1:0]   w_rsl [2], w_rel [2];
    logic [COLUMN_WIDTH-1:0] w_rsc [2], w_rec [2];

    logic [5:0]              r_fk [4];
    logic [3:0]              r_fe [4];
    logic [LINE_WIDTH-1:0]   r_fsl [4], r_fel [4];
    logic [COLUMN_WIDTH-1:0] r_fsc [4], r_fec [4];
    logic                    r_fl [4];
    logic [1:0]              r_wp, r_rp;
    logic [2:0]              r_cnt;
    logic                    w_pop;

    always_comb begin
        logic       done, adv, em, fin;
        logic [5:0] ek;
        logic [3:0] ee;
        t_opk       opk;
        logic [3:0] nx;
        logic [5:0] base;
        n_mode  = r_mode;
        n_phase = r_phase;
        n_sfx   = r_sfx;
        n_esc   = r_esc;
        n_pch   = r_pch;
        n_line  = r_line;
        n_col   = r_col;
        n_tsl   = r_tsl;
        n_tsc   = r_tsc;
        w_n     = 2'd0;
        for (int k = 0; k < 2; k++) begin
            w_rk[k]  = K_EOF;
            w_re[k]  = E_NONE;
            w_rsl[k] = '0;
            w_rsc[k] = '0;
            w_rel[k] = '0;
            w_rec[k] = '0;
        end
        done = 1'b0;
        opk  = op_kinds(r_pch);
        nx   = 4'd0;
        base = K_SHL;
        for (int p = 0; p < 4; p++) begin
            adv = 1'b0;
            em  = 1'b0;
            fin = 1'b0;
            ek  = K_EOF;
            ee  = E_NONE;
            if (!done) begin
                done = 1'b1;
                case (n_mode)
                    M_IDLE: begin
                        if (i_cls.eoi) begin
                            em = 1'b1;
                        end else begin
                            n_tsl = n_line;
                            n_tsc = n_col;
                            adv   = 1'b1;
                            if (i_cls.spc) begin
                            end else if (i_cls.sk_ok) begin
                                fin = 1'b1; ek = i_cls.sk;
                            end else if (i_cls.opst) begin
                                n_mode = M_OP; n_pch = i_cls.b;
                            end else if (i_cls.quote) begin
                                n_mode = M_STR; n_esc = 1'b0;
                            end else if (i_cls.wordc && !i_cls.dig) begin
                                n_mode = M_WORD;
                            end else if (i_cls.zero) begin
                                n_mode = M_ZERO;
                            end else if (i_cls.dig) begin
                                n_mode = M_DEC; n_phase = P_INT;
                            end else begin
                                fin = 1'b1; ek = K_ERROR; ee = E_UNKNOWN;
                            end
                        end
                    end
                    M_OP: begin
                        opk = op_kinds(n_pch);
                        if (n_pch == CH_DOT && i_cls.dig) begin
                            adv = 1'b1; n_mode = M_DEC; n_phase = P_FRAC;
                        end else if (n_pch == CH_SLASH && (i_cls.slash || i_cls.star)) begin
                            adv = 1'b1; n_mode = i_cls.slash ? M_LCOM : M_BCOM;
                        end else if (i_cls.eq && opk.eq_ok) begin
                            adv = 1'b1; fin = 1'b1; ek = opk.eq;
                        end else if (!i_cls.eoi && i_cls.b == n_pch && opk.dbl_ok) begin
                            adv = 1'b1;
                            if (n_pch == CH_LT || n_pch == CH_GT) n_mode = M_OP2;
                            else begin
                                fin = 1'b1; ek = opk.dbl;
                            end
                        end else begin
                            fin = 1'b1; ek = opk.single; done = 1'b0;
                        end
                    end
                    M_OP2: begin
                        base = (n_pch == CH_LT) ? K_SHL : K_SHR;
                        fin  = 1'b1;
                        if (i_cls.eq) begin
                            adv = 1'b1; ek = base + 6'd1;
                        end else begin
                            ek = base; done = 1'b0;
                        end
                    end
                    M_LCOM: begin
                        if (i_cls.eoi) begin
                            n_mode = M_IDLE; done = 1'b0;
                        end else begin
                            adv = 1'b1;
                            if (i_cls.nl) n_mode = M_IDLE;
                        end
                    end
                    M_BCOM, M_BSTAR: begin
                        if (i_cls.eoi) begin
                            fin = 1'b1; ek = K_ERROR; ee = E_COMMENT; done = 1'b0;
                        end else begin
                            adv = 1'b1;
                            if (n_mode == M_BSTAR && i_cls.slash) n_mode = M_IDLE;
                            else n_mode = i_cls.star ? M_BSTAR : M_BCOM;
                        end
                    end
                    M_STR: begin
                        if (i_cls.eoi) begin
                            fin = 1'b1; ek = K_ERROR; ee = E_STRING; done = 1'b0;
                        end else begin
                            adv = 1'b1;
                            if (n_esc) n_esc = 1'b0;
                            else if (i_cls.bslash) n_esc = 1'b1;
                            else if (i_cls.quote) begin
                                fin = 1'b1; ek = K_STRING;
                            end
                        end
                    end
                    M_WORD: begin
                        if (i_cls.wordc) adv = 1'b1;
                        else begin
                            fin = 1'b1; ek = K_WORD; done = 1'b0;
                        end
                    end
                    M_ZERO: begin
                        if (i_cls.dig) begin
                            adv = 1'b1; fin = 1'b1; ek = K_ERROR; ee = E_ZERO_DIG;
                        end else if (i_cls.lc_b) begin
                            adv = 1'b1; n_mode = M_BIN0;
                        end else if (i_cls.lc_o) begin
                            adv = 1'b1; n_mode = M_OCT0;
                        end else if (i_cls.lc_x) begin
                            adv = 1'b1; n_mode = M_HEX0;
                        end else begin
                            n_mode = M_DEC; n_phase = P_INT; done = 1'b0;
                        end
                    end
                    M_BIN0, M_OCT0, M_HEX0: begin
                        if ((n_mode == M_BIN0 && i_cls.bin) ||
                            (n_mode == M_OCT0 && i_cls.oct) ||
                            (n_mode == M_HEX0 && i_cls.xdg)) begin
                            adv = 1'b1; n_mode = n_mode + 5'd1;
                        end else begin
                            fin = 1'b1; ek = K_ERROR; done = 1'b0;
                            ee = (n_mode == M_BIN0) ? E_BIN :
                                 (n_mode == M_OCT0) ? E_OCT : E_HEX;
                        end
                    end
                    M_BIN, M_OCT, M_HEX: begin
                        if ((n_mode == M_BIN && i_cls.bin) ||
                            (n_mode == M_OCT && i_cls.oct) ||
                            (n_mode == M_HEX && i_cls.xdg)) begin
                            adv = 1'b1;
                        end else begin
                            n_mode = M_ISUF; n_sfx = S_NONE; done = 1'b0;
                        end
                    end
                    M_DEC: begin
                        if (n_phase == P_FRAC || n_phase == P_EXP) begin
                            if (i_cls.dig) adv = 1'b1;
                            else if (i_cls.dot) begin
                                adv = 1'b1; fin = 1'b1; ek = K_ERROR; ee = E_DOT2;
                            end else if (i_cls.lc_e) begin
                                adv = 1'b1;
                                if (n_phase == P_EXP) begin
                                    fin = 1'b1; ek = K_ERROR; ee = E_EXP2;
                                end else n_phase = P_AFTER_E;
                            end else if (i_cls.lc_fl) begin
                                adv = 1'b1; n_mode = M_FSUF; n_sfx = S_FLOAT;
                            end else begin
                                fin = 1'b1; ek = K_FLOAT; done = 1'b0;
                            end
                        end else if (n_phase == P_AFTER_E || n_phase == P_AFTER_SIGN) begin
                            if (i_cls.dig) begin
                                adv = 1'b1; n_phase = P_EXP;
                            end else if (n_phase == P_AFTER_E && i_cls.sign) begin
                                adv = 1'b1; n_phase = P_AFTER_SIGN;
                            end else begin
                                fin = 1'b1; ek = K_ERROR; ee = E_EXP; done = 1'b0;
                            end
                        end else begin
                            if (i_cls.dig) adv = 1'b1;
                            else if (i_cls.dot) begin
                                adv = 1'b1; n_phase = P_FRAC;
                            end else if (i_cls.lc_e) begin
                                adv = 1'b1; n_phase = P_AFTER_E;
                            end else begin
                                n_mode = M_ISUF; n_sfx = S_NONE; done = 1'b0;
                            end
                        end
                    end
                    M_ISUF: begin
                        if (!i_cls.lc_u && !i_cls.lc_l) begin
                            fin = 1'b1; ek = K_INTEGER; done = 1'b0;
                        end else begin
                            nx  = isuf_next(n_sfx, i_cls.lc_l);
                            adv = 1'b1;
                            if (!nx[3]) begin
                                fin = 1'b1; ek = K_ERROR; ee = E_ISUF;
                            end else n_sfx = nx[2:0];
                        end
                    end
                    M_FSUF: begin
                        if (i_cls.lc_fl) begin
                            adv = 1'b1; fin = 1'b1; ek = K_ERROR; ee = E_FSUF2;
                        end else if (i_cls.lc_e) begin
                            adv = 1'b1; fin = 1'b1; ek = K_ERROR; ee = E_FSUF_POS;
                        end else begin
                            fin = 1'b1; ek = K_FLOAT; done = 1'b0;
                        end
                    end
                    default: begin
                        n_mode = M_IDLE; done = 1'b0;
                    end
                endcase
                if (adv) begin
                    if (i_cls.nl) begin
                        if (n_line != '1) n_line = n_line + LINE_ONE;
                        n_col = COL_ONE;
                    end else if (n_col != '1) begin
                        n_col = n_col + COL_ONE;
                    end
                end
                if ((em || fin) && w_n != 2'd2) begin
                    w_rk[w_n[0]]  = ek;
                    w_re[w_n[0]]  = ee;
                    w_rsl[w_n[0]] = em ? n_line : n_tsl;
                    w_rsc[w_n[0]] = em ? n_col : n_tsc;
                    w_rel[w_n[0]] = n_line;
                    w_rec[w_n[0]] = n_col;
                    w_n = w_n + 2'd1;
                end
                if (fin) begin
                    n_mode  = M_IDLE;
                    n_phase = P_INT;
                    n_sfx   = S_NONE;
                    n_esc   = 1'b0;
                    n_pch   = '0;
                end
            end
        end
    end

    assign o_cls_take  = i_cls_valid && r_cnt <= 3'd2;
    assign o_out_valid = r_cnt != 3'd0;
    assign w_pop       = o_out_valid && i_out_ready;

    assign o_token_kind   = r_fk[r_rp];
    assign o_error_kind   = r_fe[r_rp];
    assign o_start_line   = r_fsl[r_rp];
    assign o_start_column = r_fsc[r_rp];
    assign o_end_line     = r_fel[r_rp];
    assign o_end_column   = r_fec[r_rp];
    assign o_last         = r_fl[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_phase <= P_INT;
            r_sfx   <= S_NONE;
            r_esc   <= 1'b0;
            r_pch   <= '0;
            r_line  <= LINE_ONE;
            r_col   <= COL_ONE;
            r_tsl   <= LINE_ONE;
            r_tsc   <= COL_ONE;
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_cnt   <= 3'd0;
        end else begin
            if (o_cls_take) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
                r_sfx   <= n_sfx;
                r_esc   <= n_esc;
                r_pch   <= n_pch;
                r_line  <= n_line;
                r_col   <= n_col;
                r_tsl   <= n_tsl;
                r_tsc   <= n_tsc;
                r_wp    <= r_wp + w_n;
            end
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (o_cls_take ? {1'b0, w_n} : 3'd0) - {2'b00, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_take) begin
            for (int k = 0; k < 2; k++) begin
                if (2'(k) < w_n) begin
                    r_fk[r_wp + 2'(k)]  <= w_rk[k];
                    r_fe[r_wp + 2'(k)]  <= w_re[k];
                    r_fsl[r_wp + 2'(k)] <= w_rsl[k];
                    r_fsc[r_wp + 2'(k)] <= w_rsc[k];
                    r_fel[r_wp + 2'(k)] <= w_rel[k];
                    r_fec[r_wp + 2'(k)] <= w_rec[k];
                    r_fl[r_wp + 2'(k)]  <= (2'(k) + 2'd1 == w_n);
                end
            end
        end
    end

    `CTOK_CHECK(a_cnt_bound, r_cnt <= 3'd4, "result queue overflow")
    `CTOK_CHECK(a_take_room, !o_cls_take || r_cnt <= 3'd2, "byte taken without room")
    `CTOK_CHECK(a_pos_nonzero, r_line != '0 && r_col != '0, "position fell to zero")
    `CTOK_CHECK_NEXT(a_cnt_hold, !o_cls_take && !w_pop, $stable(r_cnt),
        "queue count moved without push or pop")

endmodule

// File: hw/rtl/c_style_byte_tokenizer.sv
// ---------------------------------------------------------------------------
// c_style_byte_tokenizer
// Byte-at-a-time C-style tokenizer with source positions.
// ---------------------------------------------------------------------------
// Input channel: one source byte per transaction (i_in_valid/o_in_ready);
//   i_end_of_input closes any pending token and adds an end-of-file token.
// Output channel: one token per transaction (o_out_valid/i_out_ready), with
//   kind, error code, start and end line/column; o_last marks the final
//   token caused by one input byte. A byte yields zero, one or two tokens.
// Throughput: one byte per cycle while the result queue has two free slots;
//   the two tokens of one byte leave in turn by the queue's single output port.
// An accepted byte passes the byte queue register, then the scanner into the
//   result queue register, before its first token reaches the output.
// The scanner takes a byte only while the four-entry result queue has at
//   least two free slots, so a stalled receiver backs up through the
//   two-entry byte queue to o_in_ready.
// Reset (i_rst_n low, synchronous): both queues empty, scanner idle,
//   position line 1 column 1. Positions saturate at all ones.
// ---------------------------------------------------------------------------
module c_style_byte_tokenizer
    import ctok_pkg::*;
#(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_char_byte,
    input  logic                    i_end_of_input,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [5:0]              o_token_kind,
    output logic [3:0]              o_error_kind,
    output logic [LINE_WIDTH-1:0]   o_start_line,
    output logic [COLUMN_WIDTH-1:0] o_start_column,
    output logic [LINE_WIDTH-1:0]   o_end_line,
    output logic [COLUMN_WIDTH-1:0] o_end_column,
    output logic                    o_last
);

    logic w_cls_valid;
    logic w_cls_take;
    t_cls w_cls;

    ctok_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .o_cls_valid    (w_cls_valid),
        .o_cls          (w_cls),
        .i_cls_take     (w_cls_take)
    );

    ctok_back #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cls_valid    (w_cls_valid),
        .i_cls          (w_cls),
        .o_cls_take     (w_cls_take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_error_kind   (o_error_kind),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_end_line     (o_end_line),
        .o_end_column   (o_end_column),
        .o_last         (o_last)
    );

endmodule
